@@ design/csc_pkg.sv @@
// Shared constants, types and helper arithmetic of the climate sensor compensation block.
package csc_pkg;

  // Field widths
  localparam int RAW_T_W = 20;
  localparam int RAW_P_W = 20;
  localparam int RAW_H_W = 16;
  localparam int TEMP_W  = 32;
  localparam int PRESS_W = 32;
  localparam int HUM_W   = 17;
  localparam int CAL_W   = 48;
  localparam int HCAL_W  = 32;
  localparam int IDX_W   = 3;

  // Divider geometry: 64-bit dividend magnitude, divisor magnitude of at most 2^30
  localparam int NUM_W      = 64;
  localparam int DEN_W      = 31;
  localparam int DIV_STAGES = NUM_W;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_TEMP_CAL    = 3'd0;
  localparam logic [IDX_W-1:0] CFG_PRESS_CAL_A = 3'd1;
  localparam logic [IDX_W-1:0] CFG_PRESS_CAL_B = 3'd2;
  localparam logic [IDX_W-1:0] CFG_PRESS_CAL_C = 3'd3;
  localparam logic [IDX_W-1:0] CFG_HUM_CAL_A   = 3'd4;
  localparam logic [IDX_W-1:0] CFG_HUM_CAL_B   = 3'd5;

  // Humidity ceiling in Q10.22 before the final shift
  localparam logic [31:0] HUM_CEIL = 32'd419430400;

  // Results that ride along with the pressure division
  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    logic [HUM_W-1:0]  humidity;
    logic              inval;
    logic              neg;
  } csc_side_t;

  typedef struct packed {
    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
    csc_side_t        side;
  } csc_div_in_t;

  typedef struct packed {
    logic [NUM_W-1:0] quot;
    csc_side_t        side;
  } csc_div_out_t;

  // Low 64 bits of a 64-bit word times a 17-bit signed factor, from its two 32-bit halves
  function automatic logic [63:0] mul64x16(input logic [63:0] a, input logic signed [16:0] b);
    logic signed [49:0] lo;
    logic signed [48:0] hi;
    lo = $signed({1'b0, a[31:0]}) * b;
    hi = $signed(a[63:32]) * b;
    return {{14{lo[49]}}, lo} + {hi[31:0], 32'b0};
  endfunction

endpackage

@@ design/csc_if.sv @@
// Stream interfaces for the raw reading items and the compensated result items.
interface csc_in_if import csc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RAW_T_W-1:0] raw_temp;
  logic [RAW_P_W-1:0] raw_press;
  logic [RAW_H_W-1:0] raw_hum;

  modport source(output valid, output raw_temp, output raw_press, output raw_hum,
                 input ready);
  modport sink(input valid, input raw_temp, input raw_press, input raw_hum,
               output ready);
endinterface

interface csc_out_if import csc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TEMP_W-1:0]  temperature;
  logic [PRESS_W-1:0] pressure;
  logic [HUM_W-1:0]   humidity;
  logic               pressure_invalid;

  modport source(output valid, output temperature, output pressure, output humidity,
                 output pressure_invalid, input ready);
  modport sink(input valid, input temperature, input pressure, input humidity,
               input pressure_invalid, output ready);
endinterface

@@ design/climate_sensor_compensation.sv @@
// Top level: integer temperature, pressure and humidity compensation pipeline.
//
//  channel  | ports                          | direction | payload
//  ---------+--------------------------------+-----------+------------------------------------
//  in_ch    | valid, ready, raw_*            | sink      | raw_temp 20, raw_press 20, raw_hum 16
//  out_ch   | valid, ready, results          | source    | temperature 32s, pressure 32,
//           |                                |           | humidity 17, pressure_invalid 1
//  cfg      | cfg_we, cfg_idx, cfg_wdata     | write     | six calibration registers
//
// One item per cycle unless the output stalls; 12 front stages, 64 divider stages
// (one quotient bit each), 5 pressure finishing stages and the output register.
// The 64-stage bit-serial pressure divider sets the latency.
// Reset clears the calibration registers and all stage valid bits.
// The pipeline stalls as a whole only when the output register is held and the last
// stage is occupied; otherwise it keeps advancing and filling bubbles.
module climate_sensor_compensation import csc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  csc_in_if.sink           in_ch,
  csc_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_idx,
  input  logic [CAL_W-1:0] cfg_wdata
);

  // ---------------- calibration registers ----------------
  logic [CAL_W-1:0]  temp_cal_r, press_cal_a_r, press_cal_b_r, press_cal_c_r;
  logic [HCAL_W-1:0] hum_cal_a_r, hum_cal_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r    <= '0;
      press_cal_a_r <= '0;
      press_cal_b_r <= '0;
      press_cal_c_r <= '0;
      hum_cal_a_r   <= '0;
      hum_cal_b_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TEMP_CAL:    temp_cal_r    <= cfg_wdata;
        CFG_PRESS_CAL_A: press_cal_a_r <= cfg_wdata;
        CFG_PRESS_CAL_B: press_cal_b_r <= cfg_wdata;
        CFG_PRESS_CAL_C: press_cal_c_r <= cfg_wdata;
        CFG_HUM_CAL_A:   hum_cal_a_r   <= cfg_wdata[HCAL_W-1:0];
        CFG_HUM_CAL_B:   hum_cal_b_r   <= cfg_wdata[HCAL_W-1:0];
        default: ;
      endcase
    end
  end

  // calibration fields
  logic        [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
  logic        [7:0]  h1, h3;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;

  assign t1 = temp_cal_r[15:0];
  assign t2 = temp_cal_r[31:16];
  assign t3 = temp_cal_r[47:32];
  assign p1 = press_cal_a_r[15:0];
  assign p2 = press_cal_a_r[31:16];
  assign p3 = press_cal_a_r[47:32];
  assign p4 = press_cal_b_r[15:0];
  assign p5 = press_cal_b_r[31:16];
  assign p6 = press_cal_b_r[47:32];
  assign p7 = press_cal_c_r[15:0];
  assign p8 = press_cal_c_r[31:16];
  assign p9 = press_cal_c_r[47:32];
  assign h1 = hum_cal_a_r[7:0];
  assign h2 = hum_cal_a_r[23:8];
  assign h3 = hum_cal_a_r[31:24];
  assign h4 = hum_cal_b_r[11:0];
  assign h5 = hum_cal_b_r[23:12];
  assign h6 = hum_cal_b_r[31:24];

  // ---------------- flow control ----------------
  logic        en;
  logic        in_fire;
  logic [11:0] fv_r;
  logic [4:0]  pv_r;
  logic        out_valid_r;

  assign en           = !out_valid_r || out_ch.ready || !pv_r[4];
  assign in_ch.ready  = en;
  assign in_fire      = in_ch.valid && en;

  // ---------------- stage 1: temperature products ----------------
  logic signed [17:0] s1_td, s1_d;
  logic signed [33:0] s1_maf;
  logic signed [35:0] s1_mdf;
  logic signed [31:0] s1_ma_r, s1_md_r;
  logic [RAW_P_W-1:0] s1_rp_r;
  logic [RAW_H_W-1:0] s1_rh_r;

  assign s1_td  = $signed({1'b0, in_ch.raw_temp[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign s1_maf = s1_td * t2;
  assign s1_d   = $signed({2'b0, in_ch.raw_temp[19:4]}) - $signed({2'b0, t1});
  assign s1_mdf = s1_d * s1_d;

  // ---------------- stage 2 ----------------
  logic signed [31:0] s2_mds, s2_a_nxt;
  logic signed [47:0] s2_qf;
  logic signed [31:0] s2_a_r, s2_q_r;
  logic [RAW_P_W-1:0] s2_rp_r;
  logic [RAW_H_W-1:0] s2_rh_r;

  assign s2_mds   = s1_md_r >>> 12;
  assign s2_qf    = s2_mds * t3;
  assign s2_a_nxt = s1_ma_r >>> 11;

  // ---------------- stage 3: fine temperature ----------------
  logic signed [31:0] s3_tf_nxt, s3_tf_r;
  logic [RAW_P_W-1:0] s3_rp_r;
  logic [RAW_H_W-1:0] s3_rh_r;

  assign s3_tf_nxt = s2_a_r + (s2_q_r >>> 14);

  // ---------------- stage 4: temperature, offsets ----------------
  logic signed [31:0] s4_t5, s4_temp_nxt, s4_hx_nxt;
  logic signed [32:0] s4_v1_nxt;
  logic signed [31:0] s4_temp_r, s4_hx_r;
  logic signed [32:0] s4_v1_r;
  logic [RAW_P_W-1:0] s4_rp_r;
  logic [RAW_H_W-1:0] s4_rh_r;

  assign s4_t5       = (s3_tf_r <<< 2) + s3_tf_r + 32'sd128;
  assign s4_temp_nxt = s4_t5 >>> 8;
  assign s4_v1_nxt   = $signed({s3_tf_r[31], s3_tf_r}) - 33'sd128000;
  assign s4_hx_nxt   = s3_tf_r - 32'sd76800;

  // ---------------- stage 5: first products ----------------
  logic signed [65:0] s5_vvf;
  logic signed [48:0] s5_v1p5, s5_v1p2;
  logic signed [43:0] s5_m5f;
  logic signed [39:0] s5_m6f;
  logic signed [40:0] s5_m3f;
  logic        [63:0] s5_vv_r;
  logic signed [48:0] s5_v1p5_r, s5_v1p2_r;
  logic signed [31:0] s5_m5_r, s5_m6_r, s5_m3_r, s5_temp_r;
  logic [RAW_P_W-1:0] s5_rp_r;
  logic [RAW_H_W-1:0] s5_rh_r;

  assign s5_vvf  = s4_v1_r * s4_v1_r;
  assign s5_v1p5 = s4_v1_r * p5;
  assign s5_v1p2 = s4_v1_r * p2;
  assign s5_m5f  = s4_hx_r * h5;
  assign s5_m6f  = s4_hx_r * h6;
  assign s5_m3f  = s4_hx_r * $signed({1'b0, h3});

  // ---------------- stage 6 ----------------
  logic        [63:0] s6_vvp6_nxt, s6_vvp3_nxt;
  logic signed [31:0] s6_ls, s6_l_nxt, s6_ra_nxt, s6_rb_nxt;
  logic signed [63:0] s6_vvp6_r, s6_vvp3_r;
  logic signed [48:0] s6_v1p5_r, s6_v1p2_r;
  logic signed [31:0] s6_l_r, s6_ra_r, s6_rb_r, s6_temp_r;
  logic [RAW_P_W-1:0] s6_rp_r;

  assign s6_vvp6_nxt = mul64x16(s5_vv_r, {p6[15], p6});
  assign s6_vvp3_nxt = mul64x16(s5_vv_r, {p3[15], p3});
  assign s6_ls       = $signed({2'b0, s5_rh_r, 14'b0}) - $signed({h4, 20'b0}) - s5_m5_r
                       + 32'sd16384;
  assign s6_l_nxt    = s6_ls >>> 15;
  assign s6_ra_nxt   = s5_m6_r >>> 10;
  assign s6_rb_nxt   = (s5_m3_r >>> 11) + 32'sd32768;

  // ---------------- stage 7 ----------------
  logic        [63:0] s7_v2_nxt, s7_x_nxt;
  logic signed [63:0] s7_x3;
  logic signed [63:0] s7_rpf;
  logic        [63:0] s7_v2_r, s7_x_r;
  logic signed [31:0] s7_rph_r, s7_l_r, s7_temp_r;
  logic [RAW_P_W-1:0] s7_rp_r;

  assign s7_v2_nxt = s6_vvp6_r + ({{15{s6_v1p5_r[48]}}, s6_v1p5_r} << 17)
                     + ({{48{p4[15]}}, p4} << 35);
  // arithmetic shift kept apart so the unsigned sum cannot turn it logical
  assign s7_x3     = s6_vvp3_r >>> 8;
  assign s7_x_nxt  = s7_x3 + ({{15{s6_v1p2_r[48]}}, s6_v1p2_r} << 12);
  assign s7_rpf    = s6_ra_r * s6_rb_r;

  // ---------------- stage 8 ----------------
  logic        [63:0] s8_y_nxt, s8_num0_nxt;
  logic        [20:0] s8_pr;
  logic signed [31:0] s8_ra2;
  logic signed [47:0] s8_r2f;
  logic        [63:0] s8_y_r, s8_num0_r;
  logic signed [31:0] s8_r2_r, s8_l_r, s8_temp_r;

  assign s8_y_nxt    = mul64x16(s7_x_r + 64'h0000_8000_0000_0000, {1'b0, p1});
  assign s8_pr       = 21'd1048576 - {1'b0, s7_rp_r};
  assign s8_num0_nxt = {12'b0, s8_pr, 31'b0} - s7_v2_r;
  assign s8_ra2      = (s7_rph_r >>> 10) + 32'sd2097152;
  assign s8_r2f      = s8_ra2 * h2;

  // ---------------- stage 9: divisor, dividend ----------------
  logic        [63:0] s9_num_nxt;
  logic signed [31:0] s9_r3;
  logic signed [63:0] s9_x2f;
  logic        [DEN_W-1:0] s9_den_r;
  logic        [63:0] s9_num_r;
  logic signed [31:0] s9_x2_r, s9_temp_r;

  assign s9_num_nxt = mul64x16(s8_num0_r, 17'sd3125);
  assign s9_r3      = (s8_r2_r + 32'sd8192) >>> 14;
  assign s9_x2f     = s8_l_r * s9_r3;

  // ---------------- stage 10: magnitudes for the divider ----------------
  logic [NUM_W-1:0]   s10_nm_nxt;
  logic [DEN_W-1:0]   s10_dm_nxt;
  logic signed [31:0] s10_s;
  logic signed [63:0] s10_ssf;
  logic [NUM_W-1:0]   s10_nm_r;
  logic [DEN_W-1:0]   s10_dm_r;
  logic               s10_neg_r, s10_inv_r;
  logic signed [31:0] s10_ss_r, s10_x2_r, s10_temp_r;

  assign s10_nm_nxt = s9_num_r[63] ? (64'd0 - s9_num_r) : s9_num_r;
  assign s10_dm_nxt = s9_den_r[DEN_W-1] ? (31'd0 - s9_den_r) : s9_den_r;
  assign s10_s      = s9_x2_r >>> 15;
  assign s10_ssf    = s10_s * s10_s;

  // ---------------- stage 11 ----------------
  logic signed [31:0] s11_sss;
  logic signed [40:0] s11_tf;
  logic [NUM_W-1:0]   s11_nm_r;
  logic [DEN_W-1:0]   s11_dm_r;
  logic               s11_neg_r, s11_inv_r;
  logic signed [31:0] s11_t_r, s11_x2_r, s11_temp_r;

  assign s11_sss = s10_ss_r >>> 7;
  assign s11_tf  = s11_sss * $signed({1'b0, h1});

  // ---------------- stage 12: humidity clamp, divider input ----------------
  logic signed [31:0] s12_x3;
  logic [31:0]        s12_xc;
  csc_div_in_t        s12_nxt, s12_r;

  assign s12_x3 = s11_x2_r - (s11_t_r >>> 4);

  always_comb begin
    if (s12_x3[31]) begin
      s12_xc = '0;
    end else if (s12_x3 > HUM_CEIL) begin
      s12_xc = HUM_CEIL;
    end else begin
      s12_xc = s12_x3;
    end
    s12_nxt.num_mag          = s11_nm_r;
    s12_nxt.den_mag          = s11_dm_r;
    s12_nxt.side.temperature = s11_temp_r;
    s12_nxt.side.humidity    = s12_xc[28:12];
    s12_nxt.side.inval       = s11_inv_r;
    s12_nxt.side.neg         = s11_neg_r;
  end

  // front stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      s1_ma_r    <= s1_maf[31:0];
      s1_md_r    <= s1_mdf[31:0];
      s1_rp_r    <= in_ch.raw_press;
      s1_rh_r    <= in_ch.raw_hum;

      s2_a_r     <= s2_a_nxt;
      s2_q_r     <= s2_qf[31:0];
      s2_rp_r    <= s1_rp_r;
      s2_rh_r    <= s1_rh_r;

      s3_tf_r    <= s3_tf_nxt;
      s3_rp_r    <= s2_rp_r;
      s3_rh_r    <= s2_rh_r;

      s4_temp_r  <= s4_temp_nxt;
      s4_v1_r    <= s4_v1_nxt;
      s4_hx_r    <= s4_hx_nxt;
      s4_rp_r    <= s3_rp_r;
      s4_rh_r    <= s3_rh_r;

      s5_vv_r    <= s5_vvf[63:0];
      s5_v1p5_r  <= s5_v1p5;
      s5_v1p2_r  <= s5_v1p2;
      s5_m5_r    <= s5_m5f[31:0];
      s5_m6_r    <= s5_m6f[31:0];
      s5_m3_r    <= s5_m3f[31:0];
      s5_temp_r  <= s4_temp_r;
      s5_rp_r    <= s4_rp_r;
      s5_rh_r    <= s4_rh_r;

      s6_vvp6_r  <= s6_vvp6_nxt;
      s6_vvp3_r  <= s6_vvp3_nxt;
      s6_v1p5_r  <= s5_v1p5_r;
      s6_v1p2_r  <= s5_v1p2_r;
      s6_l_r     <= s6_l_nxt;
      s6_ra_r    <= s6_ra_nxt;
      s6_rb_r    <= s6_rb_nxt;
      s6_temp_r  <= s5_temp_r;
      s6_rp_r    <= s5_rp_r;

      s7_v2_r    <= s7_v2_nxt;
      s7_x_r     <= s7_x_nxt;
      s7_rph_r   <= s7_rpf[31:0];
      s7_l_r     <= s6_l_r;
      s7_temp_r  <= s6_temp_r;
      s7_rp_r    <= s6_rp_r;

      s8_y_r     <= s8_y_nxt;
      s8_num0_r  <= s8_num0_nxt;
      s8_r2_r    <= s8_r2f[31:0];
      s8_l_r     <= s7_l_r;
      s8_temp_r  <= s7_temp_r;

      s9_den_r   <= s8_y_r[63:33];
      s9_num_r   <= s9_num_nxt;
      s9_x2_r    <= s9_x2f[31:0];
      s9_temp_r  <= s8_temp_r;

      s10_nm_r   <= s10_nm_nxt;
      s10_dm_r   <= s10_dm_nxt;
      s10_neg_r  <= s9_num_r[63] ^ s9_den_r[DEN_W-1];
      s10_inv_r  <= (s9_den_r == '0);
      s10_ss_r   <= s10_ssf[31:0];
      s10_x2_r   <= s9_x2_r;
      s10_temp_r <= s9_temp_r;

      s11_nm_r   <= s10_nm_r;
      s11_dm_r   <= s10_dm_r;
      s11_neg_r  <= s10_neg_r;
      s11_inv_r  <= s10_inv_r;
      s11_t_r    <= s11_tf[31:0];
      s11_x2_r   <= s10_x2_r;
      s11_temp_r <= s10_temp_r;

      s12_r      <= s12_nxt;
    end
  end

  // ---------------- divider ----------------
  logic         div_v;
  csc_div_out_t div_out;

  csc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fv_r[11]),
    .in_data   (s12_r),
    .out_valid (div_v),
    .out_data  (div_out)
  );

  // ---------------- pressure finishing stages ----------------
  logic signed [63:0] p1_p_nxt;
  logic signed [63:0] p1_p_r;
  csc_side_t          p1_side_r;

  assign p1_p_nxt = div_out.side.neg ? (64'd0 - div_out.quot) : div_out.quot;

  // squared pressure split into 32-bit halves
  logic signed [63:0] p2_ps;
  logic        [63:0] p2_ll_nxt, p2_xf, p2_w2_nxt;
  logic        [63:0] p2_ll_r;
  logic        [31:0] p2_x_r;
  logic signed [63:0] p2_p_r, p2_w2_r;
  csc_side_t          p2_side_r;

  assign p2_ps     = p1_p_r >>> 13;
  assign p2_ll_nxt = p2_ps[31:0] * p2_ps[31:0];
  assign p2_xf     = p2_ps[31:0] * p2_ps[63:32];
  assign p2_w2_nxt = mul64x16(p1_p_r, {p8[15], p8});

  logic        [63:0] p3_pss_r;
  logic signed [63:0] p3_p_r, p3_w2_r;
  csc_side_t          p3_side_r;

  logic        [63:0] p4_w1_nxt;
  logic signed [63:0] p4_p_r, p4_w1_r, p4_w2_r;
  csc_side_t          p4_side_r;

  assign p4_w1_nxt = mul64x16(p3_pss_r, {p9[15], p9});

  logic signed [63:0]  p5_sum, p5_res;
  logic [PRESS_W-1:0]  p5_press_nxt, p5_press_r;
  csc_side_t           p5_side_r;

  assign p5_sum       = p4_p_r + (p4_w1_r >>> 25) + (p4_w2_r >>> 19);
  assign p5_res       = (p5_sum >>> 8) + ({{48{p7[15]}}, p7} << 4);
  assign p5_press_nxt = p4_side_r.inval ? '0 : p5_res[PRESS_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      p1_p_r     <= p1_p_nxt;
      p1_side_r  <= div_out.side;

      p2_ll_r    <= p2_ll_nxt;
      p2_x_r     <= p2_xf[31:0];
      p2_p_r     <= p1_p_r;
      p2_w2_r    <= p2_w2_nxt;
      p2_side_r  <= p1_side_r;

      p3_pss_r   <= p2_ll_r + {p2_x_r[30:0], 33'b0};
      p3_p_r     <= p2_p_r;
      p3_w2_r    <= p2_w2_r;
      p3_side_r  <= p2_side_r;

      p4_p_r     <= p3_p_r;
      p4_w1_r    <= p4_w1_nxt;
      p4_w2_r    <= p3_w2_r;
      p4_side_r  <= p3_side_r;

      p5_press_r <= p5_press_nxt;
      p5_side_r  <= p4_side_r;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
      pv_r <= '0;
    end else if (en) begin
      fv_r <= {fv_r[10:0], in_fire};
      pv_r <= {pv_r[3:0], div_v};
    end
  end

  // ---------------- output register ----------------
  logic [TEMP_W-1:0]  out_temp_r;
  logic [PRESS_W-1:0] out_press_r;
  logic [HUM_W-1:0]   out_hum_r;
  logic               out_inval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= pv_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      out_temp_r  <= p5_side_r.temperature;
      out_press_r <= p5_press_r;
      out_hum_r   <= p5_side_r.humidity;
      out_inval_r <= p5_side_r.inval;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.temperature      = out_temp_r;
  assign out_ch.pressure         = out_press_r;
  assign out_ch.humidity         = out_hum_r;
  assign out_ch.pressure_invalid = out_inval_r;

  // ---------------- assertions ----------------
  a_inval_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_inval_r |-> out_press_r == '0)
    else $error("pressure not forced to zero on invalid divisor");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_hum_r <= HUM_W'(102400))
    else $error("humidity above clamp");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> fv_r[0])
    else $error("accepted item missing from first stage");

  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r[4] && !en |=> pv_r[4] && out_valid_r)
    else $error("item lost at pipeline tail during stall");

endmodule

@@ design/csc_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage, with side payload.
module csc_div import csc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_valid,
  input  csc_div_in_t  in_data,
  output logic         out_valid,
  output csc_div_out_t out_data
);

  logic             v_r    [DIV_STAGES];
  logic [DEN_W-1:0] rem_r  [DIV_STAGES];
  logic [DEN_W-1:0] den_r  [DIV_STAGES];
  logic [NUM_W-1:0] nq_r   [DIV_STAGES];
  csc_side_t        side_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic             v_prev;
    logic [DEN_W-1:0] rem_prev;
    logic [DEN_W-1:0] den_prev;
    logic [NUM_W-1:0] nq_prev;
    csc_side_t        side_prev;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic [DEN_W-1:0] rem_nxt;
    logic [NUM_W-1:0] nq_nxt;

    // stage input: the port for the first stage, the previous stage otherwise
    if (k == 0) begin : g_first
      always_comb begin
        v_prev    = in_valid;
        rem_prev  = '0;
        den_prev  = in_data.den_mag;
        nq_prev   = in_data.num_mag;
        side_prev = in_data.side;
      end
    end else begin : g_next
      always_comb begin
        v_prev    = v_r[k-1];
        rem_prev  = rem_r[k-1];
        den_prev  = den_r[k-1];
        nq_prev   = nq_r[k-1];
        side_prev = side_r[k-1];
      end
    end

    // shift in the next dividend bit, subtract when it fits; quotient bit enters at the bottom
    always_comb begin
      trial = {rem_prev, nq_prev[NUM_W-1]};
      diff  = trial - {1'b0, den_prev};
      if (trial >= {1'b0, den_prev}) begin
        rem_nxt = diff[DEN_W-1:0];
        nq_nxt  = {nq_prev[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        nq_nxt  = {nq_prev[NUM_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_prev;
        nq_r[k]   <= nq_nxt;
        side_r[k] <= side_prev;
      end
    end
  end

  always_comb begin
    out_valid     = v_r[DIV_STAGES-1];
    out_data.quot = nq_r[DIV_STAGES-1];
    out_data.side = side_r[DIV_STAGES-1];
  end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the climate sensor compensation pipeline.
`timescale 1ns / 1ps

module tb;
  import csc_pkg::*;

  // Register index that does not exist; writes to it must be dropped
  localparam logic [IDX_W-1:0] CFG_UNUSED = 3'd6;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 90;

  typedef struct {
    bit [RAW_T_W-1:0] raw_temp;
    bit [RAW_P_W-1:0] raw_press;
    bit [RAW_H_W-1:0] raw_hum;
  } reading_t;

  typedef struct {
    bit [TEMP_W-1:0]  temperature;
    bit [PRESS_W-1:0] pressure;
    bit [HUM_W-1:0]   humidity;
    bit               inval;
  } compensated_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [CAL_W-1:0] cfg_wdata;

  csc_in_if  in_ch();
  csc_out_if out_ch();

  climate_sensor_compensation dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Local copy of the calibration registers
  bit [CAL_W-1:0]  temp_cal, press_cal_a, press_cal_b, press_cal_c;
  bit [HCAL_W-1:0] hum_cal_a, hum_cal_b;

  reading_t     pending_readings[$];
  compensated_t expected_results[$];
  int  n_in;
  int  n_mismatch;
  int  idle_cycles;
  bit  in_took;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic bit [31:0] asr32(input bit [31:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  function automatic bit [63:0] asr64(input bit [63:0] x, input int n);
    return $signed(x) >>> n;
  endfunction

  function automatic bit [31:0] sext32(input bit [31:0] v, input int bits);
    bit [31:0] m;
    m = 32'd1 << (bits - 1);
    v = v & ((32'd1 << bits) - 1);
    return (v ^ m) - m;
  endfunction

  // Signed 64-bit division, truncating toward zero
  function automatic bit [63:0] div_trunc(input bit [63:0] a, input bit [63:0] b);
    bit [63:0] ua, ub, q;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    q  = ua / ub;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  // Integer compensation of one reading set under the current calibration
  function automatic compensated_t compensate(input reading_t rd);
    compensated_t res;
    bit [31:0] rt, rh, t1, t2, t3, a, d, b, tfine;
    bit [31:0] h1, h2, h3, h4, h5, h6, x, l, r, s;
    bit [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, ps, w1, w2;
    rt = rd.raw_temp;
    rh = rd.raw_hum;
    t1 = temp_cal[15:0];
    t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
    t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};

    // temperature, 32-bit wrapping
    a = asr32(((rt >> 3) - (t1 << 1)) * t2, 11);
    d = (rt >> 4) - t1;
    b = asr32(asr32(d * d, 12) * t3, 14);
    tfine = a + b;
    res.temperature = asr32(tfine * 32'd5 + 32'd128, 8);

    // pressure, 64-bit wrapping
    p1 = press_cal_a[15:0];
    p2 = {{48{press_cal_a[31]}}, press_cal_a[31:16]};
    p3 = {{48{press_cal_a[47]}}, press_cal_a[47:32]};
    p4 = {{48{press_cal_b[15]}}, press_cal_b[15:0]};
    p5 = {{48{press_cal_b[31]}}, press_cal_b[31:16]};
    p6 = {{48{press_cal_b[47]}}, press_cal_b[47:32]};
    p7 = {{48{press_cal_c[15]}}, press_cal_c[15:0]};
    p8 = {{48{press_cal_c[31]}}, press_cal_c[31:16]};
    p9 = {{48{press_cal_c[47]}}, press_cal_c[47:32]};
    v1 = {{32{tfine[31]}}, tfine} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
    if (v1 == 64'd0) begin
      res.pressure = '0;
      res.inval = 1'b1;
    end else begin
      p  = 64'd1048576 - 64'(rd.raw_press);
      p  = div_trunc(((p << 31) - v2) * 64'd3125, v1);
      ps = asr64(p, 13);
      w1 = asr64(p9 * ps * ps, 25);
      w2 = asr64(p8 * p, 19);
      p  = asr64(p + w1 + w2, 8) + (p7 << 4);
      res.pressure = p[31:0];
      res.inval = 1'b0;
    end

    // humidity, 32-bit wrapping, clamped
    h1 = hum_cal_a[7:0];
    h2 = sext32(hum_cal_a[23:8], 16);
    h3 = hum_cal_a[31:24];
    h4 = sext32(hum_cal_b[11:0], 12);
    h5 = sext32(hum_cal_b[23:12], 12);
    h6 = sext32(hum_cal_b[31:24], 8);
    x = tfine - 32'd76800;
    l = asr32((rh << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
    r = asr32(x * h6, 10) * (asr32(x * h3, 11) + 32'd32768);
    r = asr32(r, 10) + 32'd2097152;
    r = asr32(r * h2 + 32'd8192, 14);
    x = l * r;
    s = asr32(x, 15);
    x = x - asr32(asr32(s * s, 7) * h1, 4);
    if (x[31]) x = 32'd0;
    else if (x > HUM_CEIL) x = HUM_CEIL;
    res.humidity = x[28:12];
    return res;
  endfunction

  // Sender: a held item stays until taken
  always @(negedge clk) begin
    int send_idle;
    reading_t rd;
    send_idle = (n_in < 530) ? 8 : (n_in < 1060) ? 47 : 0;
    if (rst_n && (!in_ch.valid || in_took)) begin
      if (pending_readings.size() > 0 && $urandom_range(99) >= send_idle) begin
        rd = pending_readings.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.raw_temp  <= rd.raw_temp;
        in_ch.raw_press <= rd.raw_press;
        in_ch.raw_hum   <= rd.raw_hum;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    int recv_idle;
    recv_idle = (n_in < 530) ? 47 : (n_in < 1060) ? 8 : 0;
    if (rst_n) out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Monitor: predict on input accept, check on output accept, watchdog
  always @(posedge clk) begin
    reading_t rd;
    compensated_t exp_r;
    bit in_fire, out_fire;
    in_fire  = in_ch.valid && in_ch.ready;
    out_fire = out_ch.valid && out_ch.ready;
    in_took <= rst_n && in_fire;
    if (rst_n) begin
      if (in_fire) begin
        rd.raw_temp  = in_ch.raw_temp;
        rd.raw_press = in_ch.raw_press;
        rd.raw_hum   = in_ch.raw_hum;
        expected_results.push_back(compensate(rd));
        n_in++;
      end
      if (out_fire) begin
        if (expected_results.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result item: temp %0d press %0h",
                                         $signed(out_ch.temperature), out_ch.pressure);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.temperature !== exp_r.temperature || out_ch.pressure !== exp_r.pressure ||
              out_ch.humidity !== exp_r.humidity ||
              out_ch.pressure_invalid !== exp_r.inval) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch: temp %0d/%0d press %0h/%0h hum %0d/%0d inval %0b/%0b",
                       $signed(exp_r.temperature), $signed(out_ch.temperature),
                       exp_r.pressure, out_ch.pressure, exp_r.humidity, out_ch.humidity,
                       exp_r.inval, out_ch.pressure_invalid);
          end
        end
      end
      if (in_fire || out_fire || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Drives one write; the enable stays high until the caller drops it
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_TEMP_CAL:    temp_cal    = val;
      CFG_PRESS_CAL_A: press_cal_a = val;
      CFG_PRESS_CAL_B: press_cal_b = val;
      CFG_PRESS_CAL_C: press_cal_c = val;
      CFG_HUM_CAL_A:   hum_cal_a   = val[HCAL_W-1:0];
      CFG_HUM_CAL_B:   hum_cal_b   = val[HCAL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_cal(input bit [CAL_W-1:0] t, pa, pb, pc, ha, hb);
    write_reg(CFG_TEMP_CAL, t);
    write_reg(CFG_PRESS_CAL_A, pa);
    write_reg(CFG_PRESS_CAL_B, pb);
    write_reg(CFG_PRESS_CAL_C, pc);
    write_reg(CFG_HUM_CAL_A, ha);
    write_reg(CFG_HUM_CAL_B, hb);
    // an out-of-range index must leave everything alone
    write_reg(CFG_UNUSED, CAL_W'({$urandom, $urandom}));
    cfg_we <= 1'b0;
  endtask

  // Hold off until the pipeline is empty, then let it settle
  task automatic drain();
    while (pending_readings.size() > 0 || expected_results.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic add_reading(input bit [RAW_T_W-1:0] t, input bit [RAW_P_W-1:0] p,
                             input bit [RAW_H_W-1:0] h);
    reading_t rd;
    rd.raw_temp  = t;
    rd.raw_press = p;
    rd.raw_hum   = h;
    pending_readings.push_back(rd);
  endtask

  // Corner readings: field extremes plus a typical indoor point
  task automatic add_corners();
    add_reading('0, '0, '0);
    add_reading('1, '1, '1);
    add_reading(20'd519888, 20'd415148, 16'd30000);
    add_reading('0, '1, 16'd30000);
    add_reading('1, '0, '0);
    add_reading(20'd519888, '0, '1);
  endtask

  initial begin
    bit [CAL_W-1:0] cal[6];
    n_in = 0;
    n_mismatch = 0;
    idle_cycles = 0;
    in_took = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.raw_temp = '0;
    in_ch.raw_press = '0;
    in_ch.raw_hum = '0;
    out_ch.ready = 1'b0;
    {temp_cal, press_cal_a, press_cal_b, press_cal_c, hum_cal_a, hum_cal_b} = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset calibration: P1 is zero, so every pressure is flagged invalid
    add_corners();
    drain();

    // Typical calibration
    load_cal({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
             {16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500},
             CAL_W'({8'd0, 16'd362, 8'd75}), CAL_W'({8'd30, 12'd50, 12'd324}));
    add_corners();
    add_reading(20'd480000, 20'd300000, 16'd50000);
    add_reading(20'd560000, 20'd500000, 16'd10000);
    drain();

    // All-ones calibration
    load_cal('1, '1, '1, '1, '1, '1);
    add_corners();
    drain();

    // Random phases; the first keeps typical calibration
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        load_cal({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
                 {16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500},
                 CAL_W'({8'd0, 16'd362, 8'd75}), CAL_W'({8'd30, 12'd50, 12'd324}));
      end else begin
        foreach (cal[i]) cal[i] = CAL_W'({$urandom, $urandom});
        // now and then a zero P1 to hit the invalid divisor
        if ($urandom_range(3) == 0) cal[1][15:0] = '0;
        load_cal(cal[0], cal[1], cal[2], cal[3], cal[4], cal[5]);
      end
      for (int k = 0; k < 200; k++) begin
        if ($urandom_range(1) == 0)
          add_reading(RAW_T_W'($urandom), RAW_P_W'($urandom), RAW_H_W'($urandom));
        else
          add_reading(20'(519888 + $urandom_range(80000) - 40000),
                      20'(415148 + $urandom_range(200000) - 100000),
                      16'($urandom_range(65535)));
      end
      drain();
    end

    if (n_mismatch == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
